@@ design/wccp_pkg.sv @@
// Shared types, constants and helper functions for the window chrome compositor.
// No dependencies; every other design file imports this package.
`default_nettype none

package wccp_pkg;

  localparam int MAX_WINDOWS = 8;
  localparam int COORD_BITS  = 12;
  localparam int SIZE_BITS   = COORD_BITS + 1;
  localparam int OFF_BITS    = COORD_BITS + 3;

  // Frame geometry in pixels
  localparam int BORDER     = 3;
  localparam int TITLE_H    = 18;
  localparam int CLOSE_SZ   = 12;
  localparam int CLOSE_OFS  = BORDER + 3;
  localparam int CLIENT_TOP = BORDER + TITLE_H;
  localparam int PAD_W      = 2 * BORDER;
  localparam int PAD_H      = 2 * BORDER + TITLE_H;

  localparam logic [23:0] COL_DESKTOP   = 24'h008080;
  localparam logic [23:0] COL_FACE      = 24'hC0C0C0;
  localparam logic [23:0] COL_LIGHT     = 24'hFFFFFF;
  localparam logic [23:0] COL_SHADOW    = 24'h606060;
  localparam logic [23:0] COL_OUTLINE   = 24'h000000;
  localparam logic [23:0] COL_TITLE_ON  = 24'h000080;
  localparam logic [23:0] COL_TITLE_OFF = 24'h808080;

  localparam logic [12:0] RST_SCREEN_W = 13'd1024;
  localparam logic [12:0] RST_SCREEN_H = 13'd768;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DESKTOP = 2'd0,
    KIND_CHROME  = 2'd1,
    KIND_CONTENT = 2'd2,
    KIND_OFF     = 2'd3
  } kind_t;

  typedef logic signed [OFF_BITS-1:0] off_t;

  typedef struct packed {
    logic                  func;
    logic [2:0]            rank;
    logic                  entry_valid;
    logic [2:0]            slot;
    logic [COORD_BITS-1:0] win_x;
    logic [COORD_BITS-1:0] win_y;
    logic [SIZE_BITS-1:0]  content_w;
    logic [SIZE_BITS-1:0]  content_h;
    logic                  has_content;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
  } req_t;

  typedef struct packed {
    kind_t                 kind;
    logic [23:0]           colour;
    logic [2:0]            content_slot;
    logic [COORD_BITS-1:0] content_col;
    logic [COORD_BITS-1:0] content_row;
  } rsp_t;

  // One window table entry (payload part; live bits are kept apart)
  typedef struct packed {
    logic [2:0]            slot;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [SIZE_BITS-1:0]  cw;
    logic [SIZE_BITS-1:0]  ch;
    logic                  has;
  } entry_t;

  // Window relative to the queried pixel, first stage
  typedef struct packed {
    logic                 live;
    logic [2:0]           slot;
    logic                 has;
    off_t                 dx;
    off_t                 dy;
    logic [SIZE_BITS-1:0] cw;
    logic [SIZE_BITS-1:0] ch;
  } rel_t;

  typedef struct packed {
    logic                       off;
    rel_t [MAX_WINDOWS-1:0]     win;
  } s1_t;

  // Region flags of one window, second stage
  typedef struct packed {
    logic                  hit;
    logic                  frame;
    logic                  close;
    logic                  o_top;
    logic                  o_bot;
    logic                  o_lft;
    logic                  o_rgt;
    logic                  inner;
    logic                  i_top;
    logic                  i_bot;
    logic                  i_lft;
    logic                  i_rgt;
    logic                  title;
    logic                  c_top;
    logic                  c_bot;
    logic                  c_lft;
    logic                  c_rgt;
    logic                  bar;
    logic                  content;
    logic [2:0]            slot;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } hit_t;

  typedef struct packed {
    logic                   off;
    hit_t [MAX_WINDOWS-1:0] win;
  } s2_t;

  function automatic hit_t geom_flags(rel_t w);
    hit_t h;
    off_t fw;
    off_t fh;
    off_t cx;
    off_t cy;
    fw = off_t'({2'b00, w.cw}) + off_t'(PAD_W);
    fh = off_t'({2'b00, w.ch}) + off_t'(PAD_H);
    cx = w.dx - off_t'(BORDER);
    cy = w.dy - off_t'(CLIENT_TOP);
    h.frame = (w.dx >= off_t'(0)) && (w.dy >= off_t'(0)) && (w.dx < fw) && (w.dy < fh);
    h.close = (w.dx >= off_t'(CLOSE_OFS)) && (w.dy >= off_t'(CLOSE_OFS)) &&
              (w.dx < off_t'(CLOSE_OFS + CLOSE_SZ)) && (w.dy < off_t'(CLOSE_OFS + CLOSE_SZ));
    h.hit   = w.live && (h.frame || h.close);
    h.o_top = (w.dy == off_t'(0));
    h.o_bot = (w.dy == fh - off_t'(1));
    h.o_lft = (w.dx == off_t'(0));
    h.o_rgt = (w.dx == fw - off_t'(1));
    h.inner = (w.dx >= off_t'(1)) && (w.dy >= off_t'(1)) &&
              (w.dx < fw - off_t'(1)) && (w.dy < fh - off_t'(1));
    h.i_top = (w.dy == off_t'(1));
    h.i_bot = (w.dy == fh - off_t'(2));
    h.i_lft = (w.dx == off_t'(1));
    h.i_rgt = (w.dx == fw - off_t'(2));
    h.title = (w.dx >= off_t'(BORDER)) && (w.dx < fw - off_t'(BORDER)) &&
              (w.dy >= off_t'(BORDER)) && (w.dy < off_t'(CLIENT_TOP));
    h.c_top = (w.dy == off_t'(CLOSE_OFS));
    h.c_bot = (w.dy == off_t'(CLOSE_OFS + CLOSE_SZ - 1));
    h.c_lft = (w.dx == off_t'(CLOSE_OFS));
    h.c_rgt = (w.dx == off_t'(CLOSE_OFS + CLOSE_SZ - 1));
    h.bar   = (w.dy == off_t'(CLOSE_OFS + CLOSE_SZ / 2)) &&
              (w.dx >= off_t'(CLOSE_OFS + 3)) && (w.dx < off_t'(CLOSE_OFS + CLOSE_SZ - 3));
    h.content = w.has && (cx >= off_t'(0)) && (w.dx < fw - off_t'(BORDER)) &&
                (cy >= off_t'(0)) && (w.dy < fh - off_t'(BORDER));
    h.slot = w.slot;
    h.col  = cx[COORD_BITS-1:0];
    h.row  = cy[COORD_BITS-1:0];
    return h;
  endfunction

  // Paint order: frame bevels, title bar, then the close box over all of it
  function automatic logic [23:0] chrome_colour(hit_t h, logic front);
    logic [23:0] c;
    c = COL_FACE;
    if (h.frame) begin
      if (h.o_top) c = COL_LIGHT;
      if (h.o_bot) c = COL_SHADOW;
      if (h.o_lft) c = COL_LIGHT;
      if (h.o_rgt) c = COL_SHADOW;
      if (h.inner) begin
        if (h.i_top) c = COL_LIGHT;
        if (h.i_bot) c = COL_SHADOW;
        if (h.i_lft) c = COL_LIGHT;
        if (h.i_rgt) c = COL_SHADOW;
      end
      if (h.title) c = front ? COL_TITLE_ON : COL_TITLE_OFF;
    end
    if (h.close) begin
      c = COL_FACE;
      if (h.c_top) c = COL_LIGHT;
      if (h.c_bot) c = COL_SHADOW;
      if (h.c_lft) c = COL_LIGHT;
      if (h.c_rgt) c = COL_SHADOW;
      if (h.bar)   c = COL_OUTLINE;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/wccp_fetch.sv @@
// Window table and first pipeline stage: screen clip and per-window offsets.
// Depends on wccp_pkg.
`default_nettype none

module wccp_fetch import wccp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        req_valid,
  input  wire req_t        req,
  input  wire logic [12:0] screen_w,
  input  wire logic [12:0] screen_h,
  output logic             s1_valid,
  output s1_t              s1
);

  entry_t table_mem [MAX_WINDOWS];
  logic   live      [MAX_WINDOWS];
  s1_t    s1_next;
  logic   take;

  assign take = req_valid && adv;

  // Offsets use the table as left by every earlier item
  always_comb begin
    s1_next.off = ({1'b0, req.pix_x} >= screen_w) || ({1'b0, req.pix_y} >= screen_h);
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      s1_next.win[i].live = live[i];
      s1_next.win[i].slot = table_mem[i].slot;
      s1_next.win[i].has  = table_mem[i].has;
      s1_next.win[i].dx   = off_t'({3'b000, req.pix_x}) - off_t'({3'b000, table_mem[i].x});
      s1_next.win[i].dy   = off_t'({3'b000, req.pix_y}) - off_t'({3'b000, table_mem[i].y});
      s1_next.win[i].cw   = table_mem[i].cw;
      s1_next.win[i].ch   = table_mem[i].ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_WINDOWS; i++) begin
        live[i] <= 1'b0;
      end
    end else if (take && req.func == FUNC_WRITE && 32'(req.rank) < MAX_WINDOWS) begin
      live[req.rank] <= req.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.func == FUNC_WRITE && 32'(req.rank) < MAX_WINDOWS) begin
      table_mem[req.rank].slot <= req.slot;
      table_mem[req.rank].x    <= req.win_x;
      table_mem[req.rank].y    <= req.win_y;
      table_mem[req.rank].cw   <= req.content_w;
      table_mem[req.rank].ch   <= req.content_h;
      table_mem[req.rank].has  <= req.has_content;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid && (req.func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

@@ design/wccp_geom.sv @@
// Second pipeline stage: region compares of every window against the pixel.
// Depends on wccp_pkg.
`default_nettype none

module wccp_geom import wccp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic s1_valid,
  input  wire s1_t  s1,
  output logic      s2_valid,
  output s2_t       s2
);

  s2_t s2_next;

  always_comb begin
    s2_next.off = s1.off;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      s2_next.win[i] = geom_flags(s1.win[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

@@ design/wccp_pick.sv @@
// Third pipeline stage: chrome colour per window, frontmost hit wins, result register.
// Depends on wccp_pkg.
`default_nettype none

module wccp_pick import wccp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic s2_valid,
  input  wire s2_t  s2,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  rsp_t rsp_next;

  always_comb begin
    rsp_next.kind         = KIND_DESKTOP;
    rsp_next.colour       = COL_DESKTOP;
    rsp_next.content_slot = 3'd0;
    rsp_next.content_col  = '0;
    rsp_next.content_row  = '0;
    // Walk back to front so the lowest rank that covers the pixel ends up on top
    for (int r = MAX_WINDOWS - 1; r >= 0; r--) begin
      if (s2.win[r].hit) begin
        if (s2.win[r].content) begin
          rsp_next.kind         = KIND_CONTENT;
          rsp_next.colour       = 24'd0;
          rsp_next.content_slot = s2.win[r].slot;
          rsp_next.content_col  = s2.win[r].col;
          rsp_next.content_row  = s2.win[r].row;
        end else begin
          rsp_next.kind         = KIND_CHROME;
          rsp_next.colour       = chrome_colour(s2.win[r], r == 0);
          rsp_next.content_slot = 3'd0;
          rsp_next.content_col  = '0;
          rsp_next.content_row  = '0;
        end
      end
    end
    if (s2.off) begin
      rsp_next.kind         = KIND_OFF;
      rsp_next.colour       = 24'd0;
      rsp_next.content_slot = 3'd0;
      rsp_next.content_col  = '0;
      rsp_next.content_row  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

@@ design/window_chrome_compositor_pixel_top.sv @@
// Top level of the window chrome compositor: config registers, pipeline hookup.
// Depends on wccp_pkg, wccp_fetch, wccp_geom and wccp_pick.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_t  (table write or pixel query)
//   rsp      out        rsp_valid/rsp_stall   rsp_t  (one per query, none per write)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data (screen size)
//
// One item per clock unless the pipeline is held; a query's result reaches rsp through
// the offset, region compare and frontmost select register stages, in that order
// (the first of them loads at the accepting edge).
// A table write acts on every query taken after it.
// Reset empties the window table and sets the screen to 1024 by 768.
// While a result waits under rsp_stall the whole pipeline holds and req_stall is high.
`default_nettype none

module window_chrome_compositor_pixel_top import wccp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);

  logic        adv;
  logic [12:0] screen_w;
  logic [12:0] screen_h;
  logic        s1_valid;
  s1_t         s1;
  logic        s2_valid;
  s2_t         s2;

  // Advance every stage together unless a finished result is held back
  assign adv       = !(rsp_valid && rsp_stall);
  assign req_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_w <= RST_SCREEN_W;
      screen_h <= RST_SCREEN_H;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_w <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_h <= cfg_data;
        default: ;
      endcase
    end
  end

  wccp_fetch u_fetch (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .screen_w  (screen_w),
    .screen_h  (screen_h),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  wccp_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  wccp_pick u_pick (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
